@@ rtl/hex_record_data_parser_defines.svh @@
// ----------------------------------------------------------------------------
// hex record data parser assertion macros
// shared assertion wrappers for the parser rtl
// ----------------------------------------------------------------------------
`ifndef HEX_RECORD_DATA_PARSER_DEFINES_SVH
`define HEX_RECORD_DATA_PARSER_DEFINES_SVH

// property checked only outside reset
`define HRDP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked at every edge, reset included
`define HRDP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/hrdp_pkg.sv @@
// ----------------------------------------------------------------------------
// hrdp_pkg
// types, constants and the digit conversion shared by the parser rtl
// ----------------------------------------------------------------------------
package hrdp_pkg;

    localparam int unsigned POS_W        = 10;
    localparam logic [POS_W-1:0] POS_MAX = 10'd1023;
    localparam logic [POS_W-1:0] POS_DATA_START = 10'd9;
    localparam logic [POS_W-1:0] POS_RECORD_TYPE = 10'd8;

    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_NINE  = 8'h39;
    localparam logic [7:0]  ALPHA_BIAS = 8'd55;

    localparam logic [15:0] UPPER_ADDRESS_RESET = 16'h0800;

    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_UPPER_ADDRESS = 3'd0;

    typedef struct packed {
        logic        valid;
        logic [31:0] record_address;
        logic [6:0]  halfword_index;
        logic [15:0] halfword;
        logic        last_in_record;
    } hrdp_result_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = c - CHAR_ZERO;
        end else begin
            v = c - ALPHA_BIAS;
        end
        return v[3:0];
    endfunction

endpackage

@@ rtl/hrdp_parser.sv @@
// ----------------------------------------------------------------------------
// hrdp_parser
// per-record parsing state; turns one character into at most one halfword
// ----------------------------------------------------------------------------
module hrdp_parser
    import hrdp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  logic [7:0]   char_in,
    input  logic         start_in,
    input  logic [15:0]  upper_address,
    output hrdp_result_t result
);

    logic [POS_W-1:0] char_pos_reg, char_pos_next;
    logic [7:0]       byte_count_reg, byte_count_next;
    logic [15:0]      load_offset_reg, load_offset_next;
    logic             is_data_reg, is_data_next;
    logic [11:0]      nibble_reg, nibble_next;
    logic             in_record_reg, in_record_next;

    logic [3:0]       digit;
    logic [POS_W-1:0] data_pos;
    logic [7:0]       hw_idx;
    logic [6:0]       hw_total;
    logic             in_data;
    logic             emit;

    assign digit    = hex_value(char_in);
    assign data_pos = char_pos_reg - POS_DATA_START;
    assign hw_idx   = data_pos[POS_W-1:2];
    assign hw_total = byte_count_reg[7:1];
    assign in_data  = in_record_reg && !start_in && is_data_reg
                      && (char_pos_reg >= POS_DATA_START)
                      && (hw_idx < {1'b0, hw_total});
    assign emit     = in_data && (data_pos[1:0] == 2'b11);

    always_comb begin
        result.valid          = emit;
        result.record_address = {upper_address, load_offset_reg};
        result.halfword_index = hw_idx[6:0];
        // digits arrive low byte first: d0 d1 d2 d3 -> {d2 d3 d0 d1}
        result.halfword       = {nibble_reg[3:0], digit, nibble_reg[11:8], nibble_reg[7:4]};
        result.last_in_record = (hw_idx + 8'd1) == {1'b0, hw_total};
    end

    always_comb begin
        char_pos_next    = char_pos_reg;
        byte_count_next  = byte_count_reg;
        load_offset_next = load_offset_reg;
        is_data_next     = is_data_reg;
        nibble_next      = nibble_reg;
        in_record_next   = in_record_reg;
        if (step) begin
            if (start_in) begin
                in_record_next   = 1'b1;
                char_pos_next    = {{(POS_W-1){1'b0}}, 1'b1};
                byte_count_next  = '0;
                load_offset_next = '0;
                is_data_next     = 1'b0;
                nibble_next      = '0;
            end else if (in_record_reg) begin
                if (char_pos_reg == 10'd1 || char_pos_reg == 10'd2) begin
                    byte_count_next = {byte_count_reg[3:0], digit};
                end else if (char_pos_reg >= 10'd3 && char_pos_reg <= 10'd6) begin
                    load_offset_next = {load_offset_reg[11:0], digit};
                end else if (char_pos_reg == POS_RECORD_TYPE) begin
                    is_data_next = (char_in == CHAR_ZERO);
                end else if (in_data) begin
                    nibble_next = emit ? 12'd0 : {nibble_reg[7:0], digit};
                end
                if (char_pos_reg < POS_MAX) begin
                    char_pos_next = char_pos_reg + 10'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_pos_reg    <= '0;
            byte_count_reg  <= '0;
            load_offset_reg <= '0;
            is_data_reg     <= 1'b0;
            nibble_reg      <= '0;
            in_record_reg   <= 1'b0;
        end else begin
            char_pos_reg    <= char_pos_next;
            byte_count_reg  <= byte_count_next;
            load_offset_reg <= load_offset_next;
            is_data_reg     <= is_data_next;
            nibble_reg      <= nibble_next;
            in_record_reg   <= in_record_next;
        end
    end

endmodule

@@ rtl/hex_record_data_parser.sv @@
// ----------------------------------------------------------------------------
// hex_record_data_parser
// extracts little-endian data halfwords from ascii hex data records
// ----------------------------------------------------------------------------
// Takes one character per beat, tuser high on the record's first character.
// Every fourth data digit of a data record (type '0') yields one beat with
// the full address, halfword index and tlast on the record's final halfword.
// One character is accepted every cycle while the output is drained; a
// character passes an input register and then the result register, which
// drives the halfword stream. The upper address half is written over the
// register port at address 0.
`include "hex_record_data_parser_defines.svh"

module hex_record_data_parser
    import hrdp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // character stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] character
    input  logic               s_tuser,   // [0] record_start
    // halfword stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [55:0]        m_tdata,   // [31:0] record_address, [38:32] halfword_index,
                                          // [54:39] halfword, [55] zero
    output logic               m_tlast
);

    logic [15:0]  upper_reg, upper_next;
    logic [7:0]   char_reg;
    logic         start_reg;
    logic         in_valid_reg, in_valid_next;
    logic         out_valid_reg, out_valid_next;
    logic [54:0]  out_data_reg;
    logic         out_last_reg;
    logic         advance;
    logic         s_accept;
    logic         cfg_write;
    hrdp_result_t result;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr == ADDR_UPPER_ADDRESS) ? {16'd0, upper_reg} : 32'd0;

    always_comb begin
        upper_next = upper_reg;
        if (cfg_write && paddr == ADDR_UPPER_ADDRESS) begin
            upper_next = pwdata[15:0];
        end
    end

    // input stage and result stage handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = result.valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    hrdp_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .char_in       (char_reg),
        .start_in      (start_reg),
        .upper_address (upper_reg),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg     <= UPPER_ADDRESS_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            upper_reg     <= upper_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            char_reg  <= s_tdata;
            start_reg <= s_tuser;
        end
        if (advance) begin
            out_data_reg <= {result.halfword, result.halfword_index, result.record_address};
            out_last_reg <= result.last_in_record;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};
    assign m_tlast  = out_last_reg;

    `HRDP_ASSERT(a_hold_input_when_blocked, in_valid_reg && out_valid_reg && !m_tready |-> !s_tready, "input taken while result stage blocked")
    `HRDP_ASSERT_ALWAYS(a_reset_clears_output, !aresetn |=> !m_tvalid, "result beat valid after reset")
    `HRDP_ASSERT(a_cfg_write_lands, cfg_write && paddr == ADDR_UPPER_ADDRESS |=> upper_reg == $past(pwdata[15:0]), "upper address write lost")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the hex record data parser: characters are sent as
// stream beats with random gaps, the halfword stream is drained under random
// back-pressure, and every halfword beat is compared with a local predictor
// ----------------------------------------------------------------------------
module tb;
    import hrdp_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 10;
    localparam logic [7:0]  COLON          = 8'h3A;

    typedef struct {
        logic [31:0] address;
        logic [6:0]  index;
        logic [15:0] data;
        logic        last;
    } halfword_beat_t;

    typedef enum {RX_FREE, RX_CHOPPY, RX_STALL} rx_mode_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = '0;   // [7:0] character
    logic               s_tuser  = 1'b0; // [0] record_start
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [55:0]        m_tdata;         // [31:0] address, [38:32] index, [54:39] halfword
    logic               m_tlast;

    // predictor state, owned by the beat monitor apart from upper_addr, which set_upper writes
    logic [9:0]         char_pos;
    logic [7:0]         rec_count;
    logic [15:0]        rec_offset;
    logic               rec_is_data;
    logic [11:0]        digit_buf;
    logic               rec_open;
    logic [15:0]        upper_addr = UPPER_ADDRESS_RESET;

    halfword_beat_t     pending_halfwords[$];
    int                 mismatch_count = 0;
    int                 chars_sent     = 0;
    int                 stall_cycles   = 0;
    bit                 tx_steady      = 1'b0;
    int                 rx_left        = 0;
    rx_mode_t           rx_mode        = RX_FREE;

    hex_record_data_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic logic [3:0] digit_of(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'd48;
        end else begin
            v = c - 8'd55;
        end
        return v[3:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] ch;
        if (n < 4'd10) begin
            ch = 8'h30 + {4'h0, n};
        end else begin
            ch = 8'h41 + {4'h0, n} - 8'd10;
            // lower case now and then
            if ($urandom_range(0, 9) == 0) ch = ch + 8'h20;
        end
        return ch;
    endfunction

    task automatic predict_halfword(input logic [7:0] c, input logic start);
        logic [3:0]     digit;
        logic [9:0]     rel;
        int             idx;
        int             total;
        halfword_beat_t beat;
        if (start) begin
            rec_open    = 1'b1;
            char_pos    = 10'd1;
            rec_count   = '0;
            rec_offset  = '0;
            rec_is_data = 1'b0;
            digit_buf   = '0;
        end else if (rec_open) begin
            digit = digit_of(c);
            if (char_pos == 10'd1 || char_pos == 10'd2) begin
                rec_count = {rec_count[3:0], digit};
            end else if (char_pos >= 10'd3 && char_pos <= 10'd6) begin
                rec_offset = {rec_offset[11:0], digit};
            end else if (char_pos == POS_RECORD_TYPE) begin
                rec_is_data = (c == CHAR_ZERO);
            end else if (char_pos >= POS_DATA_START && rec_is_data) begin
                rel   = char_pos - POS_DATA_START;
                idx   = int'(rel >> 2);
                total = int'(rec_count >> 1);
                if (idx < total) begin
                    if (rel[1:0] != 2'b11) begin
                        digit_buf = {digit_buf[7:0], digit};
                    end else begin
                        // first byte low, second byte high
                        beat.address = {upper_addr, rec_offset};
                        beat.index   = idx[6:0];
                        beat.data    = {digit_buf[3:0], digit, digit_buf[11:8], digit_buf[7:4]};
                        beat.last    = (idx + 1 == total);
                        pending_halfwords.push_back(beat);
                        digit_buf = '0;
                    end
                end
            end
            if (char_pos != POS_MAX) char_pos = char_pos + 10'd1;
        end
    endtask

    always @(posedge aclk) begin : beat_monitor
        halfword_beat_t want;
        if (!aresetn) begin
            char_pos    = '0;
            rec_count   = '0;
            rec_offset  = '0;
            rec_is_data = 1'b0;
            digit_buf   = '0;
            rec_open    = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_halfwords.size() == 0) begin
                    $error("halfword beat with nothing expected: tdata %h tlast %b",
                           m_tdata, m_tlast);
                    mismatch_count++;
                end else begin
                    want = pending_halfwords.pop_front();
                    if (m_tdata[31:0] !== want.address) begin
                        $error("record_address expected %h got %h", want.address, m_tdata[31:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[38:32] !== want.index) begin
                        $error("halfword_index expected %0d got %0d", want.index, m_tdata[38:32]);
                        mismatch_count++;
                    end
                    if (m_tdata[54:39] !== want.data) begin
                        $error("halfword expected %h got %h", want.data, m_tdata[54:39]);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_in_record expected %b got %b", want.last, m_tlast);
                        mismatch_count++;
                    end
                    if (m_tdata[55] !== 1'b0) begin
                        $error("tdata padding expected 0 got %b", m_tdata[55]);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) predict_halfword(s_tdata, s_tuser);
        end
    end

    // back-pressure: runs of free flow, choppy ready and stalls
    always @(posedge aclk) begin : ready_gen
        int pick;
        if (rx_left == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                rx_mode = RX_FREE;
                rx_left = $urandom_range(10, 60);
            end else if (pick < 8) begin
                rx_mode = RX_CHOPPY;
                rx_left = $urandom_range(5, 30);
            end else if (pick < 9) begin
                rx_mode = RX_STALL;
                rx_left = $urandom_range(1, 4);
            end else begin
                rx_mode = RX_STALL;
                rx_left = $urandom_range(15, 40);
            end
        end
        rx_left = rx_left - 1;
        case (rx_mode)
            RX_FREE: begin
                m_tready <= 1'b1;
            end
            RX_STALL: begin
                m_tready <= 1'b0;
            end
            default: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("hex_record_data_parser test failed");
            $finish;
        end
    end

    task automatic send_char(input logic [7:0] c, input logic start);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (tx_steady || pick < 70) begin
            gap = 0;
        end else if (pick < 92) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= c;
        s_tuser  <= start;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], 1'b0);
        end
    endtask

    task automatic apb_transfer(input bit is_write, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_UPPER_ADDRESS;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_upper(input logic [15:0] want);
        logic [31:0] rdata;
        apb_transfer(1'b0, '0, rdata);
        if (rdata[15:0] !== want) begin
            $error("upper_address expected %h got %h", want, rdata[15:0]);
            mismatch_count++;
        end
    endtask

    // register changes only once the stream has fully drained
    task automatic set_upper(input logic [15:0] value);
        logic [31:0] rdata;
        s_tvalid <= 1'b0;
        while (pending_halfwords.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        apb_transfer(1'b1, {16'h0000, value}, rdata);
        upper_addr = value;
        check_upper(value);
    endtask

    task automatic send_random_record();
        logic [7:0]  line[$];
        logic [7:0]  count_v;
        logic [15:0] offset_v;
        int          pick;
        int          cut;
        pick = $urandom_range(0, 99);
        line.push_back((pick < 90) ? COLON : 8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            count_v = 8'($urandom_range(0, 5));
        end else if (pick < 97) begin
            count_v = 8'($urandom_range(6, 16));
        end else begin
            count_v = 8'($urandom_range(17, 40));
        end
        line.push_back(hex_char(count_v[7:4]));
        line.push_back(hex_char(count_v[3:0]));
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            offset_v = 16'h0000;
        end else if (pick < 20) begin
            offset_v = 16'hFFFF;
        end else begin
            offset_v = 16'($urandom_range(0, 65535));
        end
        for (int i = 3; i >= 0; i--) begin
            line.push_back(hex_char(offset_v[4*i +: 4]));
        end
        if ($urandom_range(0, 99) < 85) begin
            line.push_back(CHAR_ZERO);
            line.push_back(CHAR_ZERO);
        end else begin
            line.push_back(hex_char(4'($urandom_range(0, 15))));
            line.push_back(8'($urandom_range(0, 255)));
        end
        repeat (2 * count_v) begin
            if ($urandom_range(0, 99) < 85) begin
                line.push_back(hex_char(4'($urandom_range(0, 15))));
            end else begin
                line.push_back(8'($urandom_range(0, 255)));
            end
        end
        // checksum and trailing junk
        repeat (2) line.push_back(hex_char(4'($urandom_range(0, 15))));
        repeat ($urandom_range(0, 2)) line.push_back(8'($urandom_range(0, 255)));
        cut = line.size();
        if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, line.size() - 1);
        tx_steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < cut; i++) begin
            send_char(line[i], i == 0);
        end
    endtask

    task automatic test_register_reset();
        check_upper(UPPER_ADDRESS_RESET);
    endtask

    task automatic test_outside_record();
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
    endtask

    task automatic test_short_record();
        // start flag on a character other than a colon, mixed-case digits
        send_char(8'hFF, 1'b1);
        send_text("02123400aBcDFF");
    endtask

    task automatic test_restart_and_odd_count();
        send_char(COLON, 1'b1);
        send_text("04");
        send_char(COLON, 1'b1);
        send_text("03FFFF00123456");
    endtask

    task automatic test_non_data_record();
        send_char(COLON, 1'b1);
        send_text("02ABCD051122");
    endtask

    task automatic test_random_traffic(input logic [15:0] upper, input int n_chars);
        int first;
        set_upper(upper);
        first = chars_sent;
        while (chars_sent - first < n_chars) send_random_record();
        tx_steady = 1'b0;
    endtask

    task automatic test_long_record();
        // long record with an odd count, back to back, then the checksum
        set_upper(16'($urandom_range(0, 65535)));
        tx_steady = 1'b1;
        send_char(COLON, 1'b1);
        send_text("41A5C300");
        repeat (130) send_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
        send_text("7E");
        tx_steady = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_register_reset();
        test_outside_record();
        test_short_record();
        test_restart_and_odd_count();
        test_non_data_record();
        test_random_traffic(16'h0000, 70);
        test_random_traffic(16'hFFFF, 70);
        test_long_record();
        test_random_traffic(16'($urandom_range(0, 65535)), 70);
        test_random_traffic(UPPER_ADDRESS_RESET, 70);
        s_tvalid <= 1'b0;
        while (pending_halfwords.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("hex_record_data_parser test passed");
        end else begin
            $display("hex_record_data_parser test failed");
        end
        $finish;
    end

endmodule
